// ===== rtl/cursor_text_buffer_macros.svh =====
// Assertion macros for the cursor text buffer.
// Used by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef CURSOR_TEXT_BUFFER_MACROS_SVH
`define CURSOR_TEXT_BUFFER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, muted in reset.
`define CTB_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cursor_text_buffer: assertion failed");

// Next-cycle implication, sampled on the rising clock edge, muted in reset.
`define CTB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cursor_text_buffer: assertion failed");

`endif

// ===== rtl/ctb_pkg.sv =====
// Shared types and constants for the cursor text buffer.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package ctb_pkg;

   localparam int CAPACITY = 32;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam logic [CNT_W-1:0] CAP_CNT   = CNT_W'(CAPACITY);
   localparam logic [7:0]       CHAR_LO   = 8'd32;
   localparam logic [7:0]       CHAR_HI   = 8'd126;
   localparam logic [6:0]       MARK_CHAR = 7'd124;

   typedef enum logic [2:0] {
      OP_INSERT = 3'd0,
      OP_DELETE = 3'd1,
      OP_LEFT   = 3'd2,
      OP_RIGHT  = 3'd3,
      OP_READ   = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_BAD_CHAR  = 2'd1,
      STS_FULL      = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CNT_HOLD = 2'd0,
      CNT_INC  = 2'd1,
      CNT_DEC  = 2'd2
   } cnt_op_type;

   typedef enum logic [1:0] {
      RD_LEFT_TOP  = 2'd0,
      RD_RIGHT_TOP = 2'd1,
      RD_WALK      = 2'd2
   } rd_sel_type;

   typedef enum logic {
      WR_AT_LEFT = 1'b0,
      WR_AT_GAP  = 1'b1
   } wr_sel_type;

   typedef enum logic {
      WD_CHAR  = 1'b0,
      WD_FETCH = 1'b1
   } wd_sel_type;

   typedef enum logic [1:0] {
      EM_ACK  = 2'd0,
      EM_TEXT = 2'd1,
      EM_MARK = 2'd2
   } emit_type;

   typedef struct packed {
      logic       latch_req;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      wd_sel_type wd_sel;
      cnt_op_type left_op;
      cnt_op_type right_op;
      logic       emit;
      emit_type   emit_kind;
      status_type status;
      logic       walk_load_left;
      logic       walk_load_right;
      logic       walk_step;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       printable;
      logic       full;
      logic       left_zero;
      logic       right_zero;
      logic       walk_last;
      logic       walk_right;
      logic       out_free;
   } sts_type;

endpackage

`default_nettype wire

// ===== rtl/ctb_datapath.sv =====
// Datapath of the cursor text buffer: request latch, character store,
// cursor counters, read-out walker and result register. Depends on ctb_pkg.
`default_nettype none

`include "cursor_text_buffer_macros.svh"

module ctb_datapath
   import ctb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [15:0] req_tdata,
   input  wire cmd_type     cmd,
   output sts_type          sts,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,
   output logic             rsp_tlast,
   output logic             rsp_tuser
);

   logic [2:0]        op_ff;
   logic [7:0]        char_ff;
   logic [6:0]        store_ff [CAPACITY];
   logic [6:0]        rd_data_ff;
   logic [CNT_W-1:0]  left_ff, left_in;
   logic [CNT_W-1:0]  right_ff, right_in;
   logic [ADDR_W-1:0] walk_ptr_ff;
   logic [CNT_W-1:0]  walk_rem_ff;
   logic              walk_right_ff;
   logic              out_valid_ff, out_valid_in;
   logic [1:0]        out_status_ff;
   logic [6:0]        out_char_ff;
   logic              out_mark_ff;
   logic              out_last_ff;
   logic [CNT_W-1:0]  out_left_ff;
   logic [CNT_W-1:0]  out_right_ff;
   logic [CNT_W:0]    fill_sum;
   logic [CNT_W-1:0]  left_m1;
   logic [CNT_W-1:0]  gap_top;
   logic [CNT_W-1:0]  gap_m1;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic [6:0]        wr_data;
   logic              out_free;

   assign fill_sum = {1'b0, left_ff} + {1'b0, right_ff};
   assign left_m1  = left_ff - CNT_W'(1);
   assign gap_top  = CAP_CNT - right_ff;
   assign gap_m1   = gap_top - CNT_W'(1);
   assign out_free = !out_valid_ff || rsp_tready;

   assign sts.op         = op_ff;
   assign sts.printable  = (char_ff >= CHAR_LO) && (char_ff <= CHAR_HI);
   assign sts.full       = fill_sum >= (CNT_W+1)'(CAPACITY);
   assign sts.left_zero  = left_ff == '0;
   assign sts.right_zero = right_ff == '0;
   assign sts.walk_last  = walk_rem_ff == CNT_W'(1);
   assign sts.walk_right = walk_right_ff;
   assign sts.out_free   = out_free;

   always_comb begin
      case (cmd.rd_sel)
         RD_LEFT_TOP:  rd_addr = left_m1[ADDR_W-1:0];
         RD_RIGHT_TOP: rd_addr = gap_top[ADDR_W-1:0];
         RD_WALK:      rd_addr = walk_ptr_ff;
         default:      rd_addr = walk_ptr_ff;
      endcase
      wr_addr = (cmd.wr_sel == WR_AT_GAP) ? gap_m1[ADDR_W-1:0] : left_ff[ADDR_W-1:0];
      wr_data = (cmd.wd_sel == WD_FETCH) ? rd_data_ff : char_ff[6:0];
   end

   always_comb begin
      case (cmd.left_op)
         CNT_INC: left_in = left_ff + CNT_W'(1);
         CNT_DEC: left_in = left_m1;
         default: left_in = left_ff;
      endcase
      case (cmd.right_op)
         CNT_INC: right_in = right_ff + CNT_W'(1);
         CNT_DEC: right_in = right_ff - CNT_W'(1);
         default: right_in = right_ff;
      endcase
      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // store and read port
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff      <= '0;
         right_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         left_ff      <= left_in;
         right_ff     <= right_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         op_ff   <= req_tdata[2:0];
         char_ff <= req_tdata[10:3];
      end
      if (cmd.walk_load_left) begin
         walk_ptr_ff   <= '0;
         walk_rem_ff   <= left_ff;
         walk_right_ff <= 1'b0;
      end else if (cmd.walk_load_right) begin
         walk_ptr_ff   <= gap_top[ADDR_W-1:0];
         walk_rem_ff   <= right_ff;
         walk_right_ff <= 1'b1;
      end else if (cmd.walk_step) begin
         walk_ptr_ff <= walk_ptr_ff + ADDR_W'(1);
         walk_rem_ff <= walk_rem_ff - CNT_W'(1);
      end
      if (cmd.emit) begin
         out_left_ff  <= left_in;
         out_right_ff <= right_in;
         case (cmd.emit_kind)
            EM_TEXT: begin
               out_status_ff <= STS_OK;
               out_char_ff   <= rd_data_ff;
               out_mark_ff   <= 1'b0;
               out_last_ff   <= walk_right_ff && (walk_rem_ff == CNT_W'(1));
            end
            EM_MARK: begin
               out_status_ff <= STS_OK;
               out_char_ff   <= MARK_CHAR;
               out_mark_ff   <= 1'b1;
               out_last_ff   <= right_ff == '0;
            end
            default: begin
               out_status_ff <= cmd.status;
               out_char_ff   <= '0;
               out_mark_ff   <= 1'b0;
               out_last_ff   <= 1'b1;
            end
         endcase
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_right_ff, out_left_ff, out_char_ff, out_status_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_mark_ff;

   `CTB_ASSERT_IMPLY(a_fill_bound, clock, reset, 1'b1, fill_sum <= (CNT_W+1)'(CAPACITY))
   `CTB_ASSERT_IMPLY(a_emit_free, clock, reset, cmd.emit, out_free)
   `CTB_ASSERT_NEXT(a_walk_keeps_counts, clock, reset, cmd.walk_step,
      $stable(left_ff) && $stable(right_ff))

endmodule

`default_nettype wire

// ===== rtl/ctb_ctrl.sv =====
// Controller state machine of the cursor text buffer: sequences edits
// and read-out through the datapath. Depends on ctb_pkg.
`default_nettype none

module ctb_ctrl
   import ctb_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_tvalid,
   output logic         req_tready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_DECODE    = 6'b000010,
      ST_SHIFT     = 6'b000100,
      ST_WALK_RD   = 6'b001000,
      ST_WALK_EMIT = 6'b010000,
      ST_MARK      = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = state_ff == ST_IDLE;

   always_comb begin
      state_in            = state_ff;
      cmd                 = '0;
      cmd.rd_sel          = RD_WALK;
      cmd.wr_sel          = WR_AT_LEFT;
      cmd.wd_sel          = WD_CHAR;
      cmd.left_op         = CNT_HOLD;
      cmd.right_op        = CNT_HOLD;
      cmd.emit_kind       = EM_ACK;
      cmd.status          = STS_OK;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (sts.op)
               OP_INSERT: begin
                  if (sts.out_free) begin
                     cmd.emit = 1'b1;
                     if (!sts.printable) begin
                        cmd.status = STS_BAD_CHAR;
                     end else if (sts.full) begin
                        cmd.status = STS_FULL;
                     end else begin
                        cmd.wr_en   = 1'b1;
                        cmd.left_op = CNT_INC;
                     end
                     state_in = ST_IDLE;
                  end
               end
               OP_DELETE: begin
                  if (sts.out_free) begin
                     cmd.emit = 1'b1;
                     if (!sts.left_zero) begin
                        cmd.left_op = CNT_DEC;
                     end
                     state_in = ST_IDLE;
                  end
               end
               OP_LEFT: begin
                  if (!sts.left_zero) begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_LEFT_TOP;
                     state_in   = ST_SHIFT;
                  end else if (sts.out_free) begin
                     cmd.emit = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
               OP_RIGHT: begin
                  if (!sts.right_zero) begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_RIGHT_TOP;
                     state_in   = ST_SHIFT;
                  end else if (sts.out_free) begin
                     cmd.emit = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
               OP_READ: begin
                  cmd.walk_load_left = 1'b1;
                  state_in = sts.left_zero ? ST_MARK : ST_WALK_RD;
               end
               default: begin
                  if (sts.out_free) begin
                     cmd.emit = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
            endcase
         end
         ST_SHIFT: begin
            if (sts.out_free) begin
               cmd.emit   = 1'b1;
               cmd.wr_en  = 1'b1;
               cmd.wd_sel = WD_FETCH;
               if (sts.op == OP_LEFT) begin
                  cmd.wr_sel   = WR_AT_GAP;
                  cmd.left_op  = CNT_DEC;
                  cmd.right_op = CNT_INC;
               end else begin
                  cmd.wr_sel   = WR_AT_LEFT;
                  cmd.left_op  = CNT_INC;
                  cmd.right_op = CNT_DEC;
               end
               state_in = ST_IDLE;
            end
         end
         ST_WALK_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_WALK;
            state_in   = ST_WALK_EMIT;
         end
         ST_WALK_EMIT: begin
            if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = EM_TEXT;
               cmd.walk_step = 1'b1;
               if (!sts.walk_last) begin
                  state_in = ST_WALK_RD;
               end else if (sts.walk_right) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_MARK;
               end
            end
         end
         ST_MARK: begin
            if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = EM_MARK;
               if (sts.right_zero) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.walk_load_right = 1'b1;
                  state_in            = ST_WALK_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/cursor_text_buffer.sv =====
// Cursor text buffer: gap-buffer line editor with a cursor; needs ctb_pkg, ctb_ctrl, ctb_datapath.
// Edits (insert, delete, move at an end, unknown op): the request is latched on transfer,
// decoded, and its result loaded; moves first read the store. Read-out reads and then emits
// each character (one read port of the store), with a marker result between the two sides.
// A new request is taken only back in idle; a stalled result holds the controller.
// Reset (synchronous, active high) empties the buffer and drops a pending result.
`default_nettype none

module cursor_text_buffer
   import ctb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel: one command per transfer
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [2:0] operation, [10:3] char_in, rest zero
   // result channel: one status per edit, or the text on read-out
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [1:0] status, [8:2] text_char,
                                         // [14:9] left_length, [20:15] right_length
   output logic             rsp_tlast,   // final result of this command
   output logic             rsp_tuser    // cursor_mark
);

   cmd_type cmd;
   sts_type sts;

   // Sequence each command: latch on transfer, decode, then read/write the
   // store and load the result register once it is free.
   ctb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Hold the store, counters, walker and result register; the result register
   // parts the two sides so a stalled consumer only holds the controller.
   ctb_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire
